[hdl/gbdd_pkg.sv]
// shared types, constants and pixel-code helpers for the ground bitplane delta decoder
// no dependencies
package gbdd_pkg;

  localparam int unsigned PIXELS_PER_ROW = 512;
  localparam int unsigned GROUP_PIXELS   = 8;
  localparam int unsigned PIXEL_W        = 8;
  localparam int unsigned CODE_W         = 2;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [CODE_W-1:0]  code_t;

  // codes named by which plane bits are set
  localparam code_t CODE_BOTH = 2'd0;
  localparam code_t CODE_HIGH = 2'd1;
  localparam code_t CODE_LOW  = 2'd2;
  localparam code_t CODE_NONE = 2'd3;

  // both set gives 0, high only 1, low only 2, neither 3
  function automatic code_t code_of(input logic lo_bit, input logic hi_bit);
    code_of = {~hi_bit, ~lo_bit};
  endfunction

  // step added to the running pixel, modulo 256
  function automatic pixel_t delta_of(input code_t prev, input code_t cur);
    pixel_t diff;
    diff = {{(PIXEL_W-CODE_W){1'b0}}, cur} - {{(PIXEL_W-CODE_W){1'b0}}, prev};
    priority if (prev == CODE_NONE && cur == CODE_BOTH) begin
      delta_of = 8'd1;
    end else if (prev == CODE_BOTH && cur == CODE_NONE) begin
      delta_of = 8'd255;
    end else if (prev == CODE_LOW && cur == CODE_BOTH) begin
      delta_of = 8'd2;
    end else if (prev == CODE_BOTH && cur == CODE_LOW) begin
      delta_of = 8'd254;
    end else begin
      delta_of = diff;
    end
  endfunction

endpackage

[hdl/ground_bitplane_delta_decoder_core.sv]
// ground bitplane delta decoder: top level with input and result registers
// depends on gbdd_pkg
//
// usage
//   slave stream s_axis carries one byte pair per transfer: the low plane in
//   tdata[7:0] and the high plane in tdata[15:8], eight pixels msb first.
//   master stream m_axis returns the eight decoded pixels of that group in
//   tdata, pixel 0 in the lowest byte, and tlast marks the last group of a row.
//   a row is ceil(PixelsPerRow / 8) groups; the running pixel and previous
//   code clear after its last group.
// pipeline and throughput
//   the input transfer loads the input register; from there the eight
//   chained 8-bit adds of a group settle into the result register.
//   one group per clock sustained while m_axis_tready stays high, set by
//   that single add chain.
// reset
//   rst_ni clears both stage valids, the running pixel, previous code and
//   group counter; the first group after reset starts a row.
// stalls
//   while m_axis_tready is low the result holds and one more group may sit
//   in the input register; s_axis_tready falls only when both are full.
module ground_bitplane_delta_decoder_core #(
  parameter int unsigned PixelsPerRow = gbdd_pkg::PIXELS_PER_ROW
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // plane_low_byte, plane_high_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // pixel_0 .. pixel_7
  output logic        m_axis_tlast    // row_end
);
  import gbdd_pkg::*;

  localparam int unsigned GroupsRaw    = (PixelsPerRow + GROUP_PIXELS - 1) / GROUP_PIXELS;
  localparam int unsigned GroupsPerRow = (GroupsRaw == 0) ? 1 : GroupsRaw;
  localparam int unsigned GroupW       = (GroupsPerRow > 1) ? $clog2(GroupsPerRow) : 1;
  localparam logic [GroupW-1:0] LastGroup = GroupW'(GroupsPerRow - 1);

  // input register
  logic        in_valid_q;
  logic [7:0]  lo_q, hi_q;
  // result register
  logic        out_valid_q;
  logic [63:0] out_data_q, out_data_d;
  logic        out_last_q;
  // decode state
  pixel_t              running_q, running_d;
  code_t               prev_code_q, prev_code_d;
  logic [GroupW-1:0]   group_q;
  logic                row_last;
  logic                advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign row_last      = (group_q == LastGroup);

  // eight chained steps: emit the running value, then add the delta
  always_comb begin
    pixel_t pix;
    code_t  prev, cur;
    pix        = running_q;
    prev       = prev_code_q;
    out_data_d = '0;
    for (int k = 0; k < GROUP_PIXELS; k++) begin
      cur = code_of(lo_q[GROUP_PIXELS-1-k], hi_q[GROUP_PIXELS-1-k]);
      out_data_d[k*PIXEL_W +: PIXEL_W] = pix;
      pix  = pix + delta_of(prev, cur);
      prev = cur;
    end
    running_d   = row_last ? '0 : pix;
    prev_code_d = row_last ? CODE_BOTH : prev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      running_q   <= '0;
      prev_code_q <= CODE_BOTH;
      group_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        running_q   <= running_d;
        prev_code_q <= prev_code_d;
        group_q     <= row_last ? '0 : group_q + 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      lo_q <= s_axis_tdata[7:0];
      hi_q <= s_axis_tdata[15:8];
    end
    if (advance) begin
      out_data_q <= out_data_d;
      out_last_q <= row_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
